// ----- src/rotation_matrix_to_quaternion_assert.svh -----
// assertion macros for the rotation matrix to quaternion block
`ifndef ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define RMQ_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// condition must hold in the cycle after the trigger
`define RMQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- src/rmq_pkg.sv -----
// shared constants for the rotation matrix to quaternion block
package rmq_pkg;
    localparam int FRAC_BITS_DEF = 14;
    localparam int NUM_ELEM      = 9;
    localparam int ELEM_W        = 16;
    localparam int NUM_COMP      = 4;
    localparam int QUAT_W        = 16;
    localparam int IN_TDATA_W    = NUM_ELEM * ELEM_W;
    localparam int OUT_TDATA_W   = NUM_COMP * QUAT_W;
    localparam int LEN_W         = 64;
    localparam int ROOT_STEPS    = 32;
    localparam int NORM_STEPS    = 5;
    localparam int QUO_BITS      = 16;
endpackage

// ----- src/rotation_matrix_to_quaternion.sv -----
// rotation matrix to unit quaternion, fully pipelined
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata: m11..m33, 16 bits each
//  m_      | out | m_tvalid/m_tready  | m_tdata: quat x,y,z,w; m_tuser: degenerate
//
// one transfer per cycle in each direction while the output is not stalled
// the pipeline depth comes mostly from the 32-step square root chain and the 16-step
// restoring divider lanes, one step per register stage
// when m_tvalid is high and m_tready low the whole pipeline holds
// aresetn clears only the valid bits; data registers are not reset
module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // m11, m12, m13, m21, m22, m23, m31, m32, m33 from bit 0 up
    input  logic [rmq_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // quat_x, quat_y, quat_z, quat_w from bit 0 up
    output logic [rmq_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // degenerate
    output logic                               m_tuser
);

    localparam int EW    = rmq_pkg::ELEM_W;
    localparam int NC    = rmq_pkg::NUM_COMP;
    localparam int QW    = rmq_pkg::QUAT_W;
    localparam int LW    = rmq_pkg::LEN_W;
    localparam int RS    = rmq_pkg::ROOT_STEPS;
    localparam int NN    = rmq_pkg::NORM_STEPS;
    localparam int QB    = rmq_pkg::QUO_BITS;
    localparam int MW    = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 1;
    localparam int SW    = MW + 1;
    localparam int ONE   = 1 << FRAC_BITS;
    localparam int LIM   = (ONE < 32767) ? ONE : 32767;
    localparam int NM    = NN + RS;
    localparam int SQ_END = 2 + NM;
    localparam int DP_IDX = SQ_END + 1;
    localparam int NS    = DP_IDX + QB + 2;

    logic          adv;
    logic [NS-1:0] vld_reg;

    assign adv      = !vld_reg[NS-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[NS-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NS-2:0], s_tvalid};
        end
    end

    // stage 1: branch select and raw vector
    logic [MW-1:0] s1_mag_reg [0:NC-1];
    logic [NC-1:0] s1_sgn_reg;
    logic          s1_deg_reg;
    logic [MW-1:0] s1_mag_next [0:NC-1];
    logic [NC-1:0] s1_sgn_next;
    logic          s1_deg_next;

    always_comb begin
        logic signed [SW-1:0] a [0:8];
        logic signed [SW-1:0] v [0:NC-1];
        logic signed [SW-1:0] t;
        logic signed [SW-1:0] r;
        logic signed [SW-1:0] one_s;
        logic signed [SW-1:0] neg;
        one_s = SW'(ONE);
        for (int e = 0; e < 9; e++) begin
            a[e] = SW'($signed(s_tdata[e*EW +: EW]));
        end
        t = a[0] + a[4] + a[8];
        r = '0;
        s1_deg_next = 1'b0;
        priority if (t > 0) begin
            v[0] = a[5] - a[7];
            v[1] = a[6] - a[2];
            v[2] = a[1] - a[3];
            v[3] = t + one_s;
        end else if (a[0] >= a[4] && a[0] >= a[8]) begin
            r = one_s + a[0] - a[4] - a[8];
            v[0] = r;
            v[1] = a[1] + a[3];
            v[2] = a[2] + a[6];
            v[3] = a[5] - a[7];
            s1_deg_next = (r <= 0);
        end else if (a[4] > a[8]) begin
            r = one_s + a[4] - a[0] - a[8];
            v[0] = a[3] + a[1];
            v[1] = r;
            v[2] = a[7] + a[5];
            v[3] = a[6] - a[2];
            s1_deg_next = (r <= 0);
        end else begin
            r = one_s + a[8] - a[0] - a[4];
            v[0] = a[6] + a[2];
            v[1] = a[7] + a[5];
            v[2] = r;
            v[3] = a[1] - a[3];
            s1_deg_next = (r <= 0);
        end
        for (int i = 0; i < NC; i++) begin
            neg = -v[i];
            s1_sgn_next[i] = v[i][SW-1];
            s1_mag_next[i] = v[i][SW-1] ? neg[MW-1:0] : v[i][MW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_mag_reg <= s1_mag_next;
            s1_sgn_reg <= s1_sgn_next;
            s1_deg_reg <= s1_deg_next;
        end
    end

    // stage 2: squares
    logic [LW-1:0] s2_sq_reg  [0:NC-1];
    logic [MW-1:0] s2_mag_reg [0:NC-1];
    logic [NC-1:0] s2_sgn_reg;
    logic          s2_deg_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < NC; i++) begin
                s2_sq_reg[i] <= LW'((2*MW)'(s1_mag_reg[i]) * (2*MW)'(s1_mag_reg[i]));
            end
            s2_mag_reg <= s1_mag_reg;
            s2_sgn_reg <= s1_sgn_reg;
            s2_deg_reg <= s1_deg_reg;
        end
    end

    // stage 3 is entry 0 of the carry arrays; then normalize, then root
    logic [LW-1:0] nm_len_reg [0:NN];
    logic [MW-1:0] cm_mag_reg [0:NM][0:NC-1];
    logic [NC-1:0] cm_sgn_reg [0:NM];
    logic          cm_deg_reg [0:NM];
    logic [4:0]    cm_k_reg   [0:NM];
    logic [LW-1:0] len_sum;

    assign len_sum = s2_sq_reg[0] + s2_sq_reg[1] + s2_sq_reg[2] + s2_sq_reg[3];

    always_ff @(posedge aclk) begin
        if (adv) begin
            nm_len_reg[0] <= len_sum;
            cm_mag_reg[0] <= s2_mag_reg;
            cm_sgn_reg[0] <= s2_sgn_reg;
            cm_deg_reg[0] <= s2_deg_reg || (len_sum == '0);
            cm_k_reg[0]   <= '0;
        end
    end

    for (genvar p = 1; p <= NM; p++) begin : g_carry
        always_ff @(posedge aclk) begin
            if (adv) begin
                cm_mag_reg[p] <= cm_mag_reg[p-1];
                cm_sgn_reg[p] <= cm_sgn_reg[p-1];
                cm_deg_reg[p] <= cm_deg_reg[p-1];
            end
        end
    end

    // shift left by an even count until bit 60 or 61 is set
    for (genvar j = 0; j < NN; j++) begin : g_norm
        localparam int SH = 32 >> j;
        localparam int KI = 16 >> j;
        logic zero_top;
        assign zero_top = (nm_len_reg[j][LW-1 -: SH+2] == '0);
        always_ff @(posedge aclk) begin
            if (adv) begin
                nm_len_reg[j+1] <= zero_top ? (nm_len_reg[j] << SH) : nm_len_reg[j];
                cm_k_reg[j+1]   <= zero_top ? (cm_k_reg[j] + 5'(KI)) : cm_k_reg[j];
            end
        end
    end

    for (genvar b = NN + 1; b <= NM; b++) begin : g_kcarry
        always_ff @(posedge aclk) begin
            if (adv) begin
                cm_k_reg[b] <= cm_k_reg[b-1];
            end
        end
    end

    // square root, two radicand bits per stage
    logic [LW-1:0] sq_n_reg   [0:RS-1];
    logic [LW-1:0] sq_res_reg [0:RS-1];

    for (genvar b = 0; b < RS; b++) begin : g_root
        localparam logic [LW-1:0] BIT = LW'(1) << (LW - 2 - 2*b);
        logic [LW-1:0] n_in;
        logic [LW-1:0] res_in;
        logic [LW-1:0] trial;
        if (b == 0) begin : g_first
            assign n_in   = nm_len_reg[NN];
            assign res_in = '0;
        end else begin : g_rest
            assign n_in   = sq_n_reg[b-1];
            assign res_in = sq_res_reg[b-1];
        end
        assign trial = res_in + BIT;
        always_ff @(posedge aclk) begin
            if (adv) begin
                if (n_in >= trial) begin
                    sq_n_reg[b]   <= n_in - trial;
                    sq_res_reg[b] <= (res_in >> 1) + BIT;
                end else begin
                    sq_n_reg[b]   <= n_in;
                    sq_res_reg[b] <= res_in >> 1;
                end
            end
        end
    end

    // divider setup: rounded dividend, overflow test against the root
    logic [31:0]   root;
    logic [6:0]    dp_sh;
    logic [31:0]   dp_rem_reg [0:NC-1];
    logic [QB-1:0] dp_low_reg [0:NC-1];
    logic [NC-1:0] dp_ovf_reg;
    logic [NC-1:0] dp_sgn_reg;
    logic          dp_deg_reg;
    logic [31:0]   dp_s_reg;

    assign root  = sq_res_reg[RS-1][31:0];
    assign dp_sh = 7'(cm_k_reg[NM]) + 7'(FRAC_BITS);

    for (genvar i = 0; i < NC; i++) begin : g_prep
        logic [LW-1:0] num;
        logic [LW-1:0] dvd;
        assign num = LW'(cm_mag_reg[NM][i]) << dp_sh;
        assign dvd = num + LW'(root >> 1);
        always_ff @(posedge aclk) begin
            if (adv) begin
                dp_rem_reg[i] <= dvd[QB +: 32];
                dp_low_reg[i] <= dvd[QB-1:0];
                dp_ovf_reg[i] <= (dvd[LW-1:QB] >= (LW-QB)'(root));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dp_sgn_reg <= cm_sgn_reg[NM];
            dp_deg_reg <= cm_deg_reg[NM];
            dp_s_reg   <= root;
        end
    end

    // restoring division, one quotient bit per stage in each lane
    logic [31:0]   dv_rem_reg [0:QB-1][0:NC-1];
    logic [QB-1:0] dv_q_reg   [0:QB-1][0:NC-1];
    logic [QB-1:0] dv_low_reg [0:QB-1][0:NC-1];
    logic [NC-1:0] dv_ovf_reg [0:QB-1];
    logic [NC-1:0] dv_sgn_reg [0:QB-1];
    logic          dv_deg_reg [0:QB-1];
    logic [31:0]   dv_s_reg   [0:QB-1];

    for (genvar j = 0; j < QB; j++) begin : g_div
        logic [31:0]   s_in;
        logic [31:0]   rem_in [0:NC-1];
        logic [QB-1:0] q_in   [0:NC-1];
        logic [QB-1:0] low_in [0:NC-1];
        if (j == 0) begin : g_first
            assign s_in   = dp_s_reg;
            assign rem_in = dp_rem_reg;
            assign low_in = dp_low_reg;
            for (genvar i = 0; i < NC; i++) begin : g_q0
                assign q_in[i] = '0;
            end
            always_ff @(posedge aclk) begin
                if (adv) begin
                    dv_ovf_reg[j] <= dp_ovf_reg;
                    dv_sgn_reg[j] <= dp_sgn_reg;
                    dv_deg_reg[j] <= dp_deg_reg;
                end
            end
        end else begin : g_rest
            assign s_in   = dv_s_reg[j-1];
            assign rem_in = dv_rem_reg[j-1];
            assign low_in = dv_low_reg[j-1];
            assign q_in   = dv_q_reg[j-1];
            always_ff @(posedge aclk) begin
                if (adv) begin
                    dv_ovf_reg[j] <= dv_ovf_reg[j-1];
                    dv_sgn_reg[j] <= dv_sgn_reg[j-1];
                    dv_deg_reg[j] <= dv_deg_reg[j-1];
                end
            end
        end
        for (genvar i = 0; i < NC; i++) begin : g_lane
            logic [32:0] trial;
            logic        fits;
            assign trial = {rem_in[i], low_in[i][QB-1-j]};
            assign fits  = (trial >= {1'b0, s_in});
            always_ff @(posedge aclk) begin
                if (adv) begin
                    dv_rem_reg[j][i] <= fits ? 32'(trial - {1'b0, s_in}) : trial[31:0];
                    dv_q_reg[j][i]   <= {q_in[i][QB-2:0], fits};
                    dv_low_reg[j][i] <= low_in[i];
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                dv_s_reg[j] <= s_in;
            end
        end
    end

    // output stage: clamp, sign, degenerate override
    logic [rmq_pkg::OUT_TDATA_W-1:0] out_tdata_reg;
    logic [rmq_pkg::OUT_TDATA_W-1:0] out_tdata_next;
    logic                            out_tuser_reg;

    always_comb begin
        logic [QW-1:0] q;
        for (int i = 0; i < NC; i++) begin
            q = dv_q_reg[QB-1][i];
            if (dv_ovf_reg[QB-1][i] || q > QW'(LIM)) begin
                q = QW'(LIM);
            end
            if (dv_sgn_reg[QB-1][i]) begin
                q = -q;
            end
            out_tdata_next[i*QW +: QW] = dv_deg_reg[QB-1] ? '0 : q;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_tdata_reg <= out_tdata_next;
            out_tuser_reg <= dv_deg_reg[QB-1];
        end
    end

    assign m_tdata = out_tdata_reg;
    assign m_tuser = out_tuser_reg;

`include "rotation_matrix_to_quaternion_assert.svh"

    `RMQ_ASSERT_SAME(a_degen_zero, aclk, aresetn, m_tvalid && m_tuser, m_tdata == '0)
    `RMQ_ASSERT_SAME(a_unit_nonzero, aclk, aresetn, m_tvalid && !m_tuser, m_tdata != '0)
    `RMQ_ASSERT_SAME(a_root_normalized, aclk, aresetn, vld_reg[SQ_END] && !cm_deg_reg[NM], sq_res_reg[RS-1][31] || sq_res_reg[RS-1][30])
    `RMQ_ASSERT_NEXT(a_stall_holds, aclk, aresetn, !adv, $stable(vld_reg))

endmodule

// ----- tb/rotation_matrix_to_quaternion_test.sv -----
// self-checking testbench for the rotation matrix to quaternion block
module rotation_matrix_to_quaternion_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_ELEM    = rmq_pkg::NUM_ELEM;
    localparam int ELEM_W      = rmq_pkg::ELEM_W;
    localparam int QUAT_W      = rmq_pkg::QUAT_W;
    localparam int IN_TDATA_W  = rmq_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W = rmq_pkg::OUT_TDATA_W;
    localparam int FRAC = rmq_pkg::FRAC_BITS_DEF;
    localparam longint ONE = longint'(1) << FRAC;
    localparam int LAT = 58;
    localparam int RAND_ITEMS = 1100;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic               degen;
        logic [QUAT_W-1:0]  qw;
        logic [QUAT_W-1:0]  qz;
        logic [QUAT_W-1:0]  qy;
        logic [QUAT_W-1:0]  qx;
    } quat_t;

    typedef struct {
        logic [ELEM_W-1:0] m [NUM_ELEM];
        logic              known;
        quat_t             q;
    } vec_row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // m11, m12, m13, m21, m22, m23, m31, m32, m33 from bit 0 up
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // quat_x, quat_y, quat_z, quat_w from bit 0 up
    logic [OUT_TDATA_W-1:0] m_tdata;
    // degenerate
    logic                   m_tuser;

    quat_t  pending_quats[$];
    int     mismatches = 0;
    longint cycles = 0;
    logic   stim_done = 1'b0;

    rotation_matrix_to_quaternion uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch at cycle %0d: %s got %0d want %0d", cycles, what, got, want);
        mismatches++;
    endtask

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic quat_t shepperd_quat(input logic [ELEM_W-1:0] m [NUM_ELEM]);
        longint a [NUM_ELEM];
        longint v [4];
        longint tr, r, q, lim;
        longint unsigned len, s, num, mg;
        int k;
        logic degen;
        quat_t res;
        for (int i = 0; i < NUM_ELEM; i++) a[i] = longint'($signed(m[i]));
        lim = ONE < 32767 ? ONE : 32767;
        tr = a[0] + a[4] + a[8];
        degen = 1'b0;
        r = 0;
        if (tr > 0) begin
            v[0] = a[5] - a[7]; v[1] = a[6] - a[2]; v[2] = a[1] - a[3]; v[3] = tr + ONE;
        end else if (a[0] >= a[4] && a[0] >= a[8]) begin
            r = ONE + a[0] - a[4] - a[8];
            v[0] = r; v[1] = a[1] + a[3]; v[2] = a[2] + a[6]; v[3] = a[5] - a[7];
            degen = (r <= 0);
        end else if (a[4] > a[8]) begin
            r = ONE + a[4] - a[0] - a[8];
            v[0] = a[3] + a[1]; v[1] = r; v[2] = a[7] + a[5]; v[3] = a[6] - a[2];
            degen = (r <= 0);
        end else begin
            r = ONE + a[8] - a[0] - a[4];
            v[0] = a[6] + a[2]; v[1] = a[7] + a[5]; v[2] = r; v[3] = a[1] - a[3];
            degen = (r <= 0);
        end
        len = 0;
        if (!degen) begin
            for (int i = 0; i < 4; i++) begin
                mg = v[i] < 0 ? -v[i] : v[i];
                len += mg * mg;
            end
            if (len == 0) degen = 1'b1;
        end
        res = '0;
        if (degen) begin
            res.degen = 1'b1;
            return res;
        end
        k = 0;
        while (len < (64'd1 << 60)) begin
            len <<= 2;
            k++;
        end
        s = int_sqrt(len);
        for (int i = 0; i < 4; i++) begin
            mg = v[i] < 0 ? -v[i] : v[i];
            num = (mg << k) << FRAC;
            q = longint'((num + (s >> 1)) / s);
            if (q > lim) q = lim;
            if (v[i] < 0) q = -q;
            case (i)
                0: res.qx = q[QUAT_W-1:0];
                1: res.qy = q[QUAT_W-1:0];
                2: res.qz = q[QUAT_W-1:0];
                default: res.qw = q[QUAT_W-1:0];
            endcase
        end
        return res;
    endfunction

    // result side: random stalls and field-by-field check
    initial begin : result_side
        int stall;
        quat_t want, got;
        @(posedge aclk iff aresetn);
        forever begin
            stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                  : ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
            if (stall > 0 && !stim_done) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                got = {m_tuser, m_tdata};
                if (pending_quats.size() == 0) begin
                    report("unexpected transfer", 0, 0);
                end else begin
                    want = pending_quats.pop_front();
                    if (got.qx !== want.qx) report("quat_x", $signed(got.qx), $signed(want.qx));
                    if (got.qy !== want.qy) report("quat_y", $signed(got.qy), $signed(want.qy));
                    if (got.qz !== want.qz) report("quat_z", $signed(got.qz), $signed(want.qz));
                    if (got.qw !== want.qw) report("quat_w", $signed(got.qw), $signed(want.qw));
                    if (got.degen !== want.degen) report("degenerate", got.degen, want.degen);
                end
            end
        end
    end

    task automatic send_matrix(input logic [ELEM_W-1:0] m [NUM_ELEM], input logic known,
                               input quat_t typed);
        int gap;
        quat_t want;
        gap = ($urandom_range(0, 11) == 0) ? $urandom_range(8, 30)
            : ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        want = shepperd_quat(m);
        if (known && want !== typed) report("directed row table", 0, 1);
        for (int i = 0; i < NUM_ELEM; i++) s_tdata[i*ELEM_W +: ELEM_W] <= m[i];
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_quats.push_back(known ? typed : want);
    endtask

    function automatic logic [ELEM_W-1:0] rand_elem(input int mode);
        case (mode)
            0: return ELEM_W'($urandom);
            1: return ELEM_W'($urandom_range(0, 2*ONE) - ONE);
            default: return ELEM_W'($urandom_range(0, 64) - 32);
        endcase
    endfunction

    initial begin : stimulus
        vec_row_t rows [$];
        vec_row_t row;
        logic [ELEM_W-1:0] m [NUM_ELEM];
        int mode;
        logic [ELEM_W-1:0] mx, mn, o;
        mx = 16'h7FFF; mn = 16'h8000; o = ELEM_W'(ONE);

        // identity: trace branch, w = one
        row.m = '{o, 0, 0, 0, o, 0, 0, 0, o}; row.known = 1;
        row.q = '{degen: 0, qw: QUAT_W'(ONE), qz: 0, qy: 0, qx: 0}; rows.push_back(row);
        // zero matrix: m11 branch, r = one, x = one
        row.m = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; row.known = 1;
        row.q = '{degen: 0, qw: 0, qz: 0, qy: 0, qx: QUAT_W'(ONE)}; rows.push_back(row);
        // all most negative: m11 branch, root argument still positive
        row.known = 0;
        row.m = '{mn, mn, mn, mn, mn, mn, mn, mn, mn}; rows.push_back(row);
        // rotations of pi about each axis
        row.m = '{o, 0, 0, 0, -o, 0, 0, 0, -o}; rows.push_back(row);
        row.m = '{-o, 0, 0, 0, o, 0, 0, 0, -o}; rows.push_back(row);
        row.m = '{-o, 0, 0, 0, -o, 0, 0, 0, o}; rows.push_back(row);
        // very negative diagonals in the m22 and m33 branches
        row.m = '{mn, 0, 0, 0, 16'hC000, 0, 0, 0, 16'hA000}; rows.push_back(row);
        row.m = '{mn, 0, 0, 0, 16'hA000, 0, 0, 0, 16'hC000}; rows.push_back(row);
        // extremes everywhere
        row.m = '{mx, mx, mx, mx, mx, mx, mx, mx, mx}; rows.push_back(row);
        row.m = '{mx, mn, mx, mn, mx, mn, mx, mn, mx}; rows.push_back(row);
        row.m = '{mn, mx, mn, mx, mn, mx, mn, mx, mn}; rows.push_back(row);
        row.m = '{0, mx, mn, mn, 0, mx, mx, mn, 0}; rows.push_back(row);
        // trace exactly zero, with and without ties on the diagonal
        row.m = '{0, 1, 2, 3, 0, 4, 5, 6, 0}; rows.push_back(row);
        row.m = '{-o, 5, 7, 9, o, 11, 13, 15, 0}; rows.push_back(row);
        // 90 degrees about z and about x
        row.m = '{0, -o, 0, o, 0, 0, 0, 0, o}; rows.push_back(row);
        row.m = '{o, 0, 0, 0, 0, -o, 0, o, 0}; rows.push_back(row);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) send_matrix(rows[i].m, rows[i].known, rows[i].q);

        for (int n = 0; n < RAND_ITEMS; n++) begin
            mode = $urandom_range(0, 2);
            for (int i = 0; i < NUM_ELEM; i++) m[i] = rand_elem(mode);
            // push the diagonal toward non-trace branches now and then
            if ($urandom_range(0, 2) == 0) begin
                m[0] = ELEM_W'($signed(m[0]) > 0 ? -m[0] : m[0]);
                m[4] = ELEM_W'($signed(m[4]) > 0 ? -m[4] : m[4]);
                m[8] = ELEM_W'($signed(m[8]) > 0 ? -m[8] : m[8]);
            end
            send_matrix(m, 1'b0, '0);
        end
        s_tvalid <= 1'b0;
        stim_done = 1'b1;

        while (pending_quats.size() != 0) @(posedge aclk);
        repeat (LAT + 10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
